// ===== src/slm_pkg.sv =====
// shared types and constants of the sorted list merger
package slm_pkg;

   localparam int LIST_DEPTH_DEF = 32;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int LEN_W          = 6;
   localparam int VALUE_W        = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   // register index, taken from csr address bit 2
   localparam logic REG_LEN_FIRST  = 1'b0;
   localparam logic REG_LEN_SECOND = 1'b1;

   typedef struct packed {
      logic                      from_second;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] merged_value;
      logic                      came_from_second;
      logic                      is_last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic empty;
      logic last;
   } status_type;

endpackage

// ===== src/slm_ram.sv =====
// generic single-port-write ram with registered read
module slm_ram #(
   parameter int WIDTH = slm_pkg::DATA_WIDTH_DEF,
   parameter int DEPTH = slm_pkg::LIST_DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/slm_datapath.sv =====
// list stores, fill counters, merge pointers and result register
module slm_datapath #(
   parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
   parameter int DATA_WIDTH = slm_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  slm_pkg::cmd_type           cmd,
   input  slm_pkg::req_type           req_data,
   input  logic [slm_pkg::LEN_W-1:0]  len_first,
   input  logic [slm_pkg::LEN_W-1:0]  len_second,
   output slm_pkg::status_type        status,
   output slm_pkg::rsp_type           rsp_data
);

   localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   logic [CNT_W-1:0] na, nb;
   logic [CNT_W-1:0] fill_a_ff, fill_a_in, fill_b_ff, fill_b_in;
   logic [CNT_W-1:0] fill_a_next, fill_b_next;
   logic [CNT_W-1:0] ia_ff, ia_in, ib_ff, ib_in, ia_step, ib_step;
   logic             wr_a, wr_b, done;
   logic             a_left, b_left, take_a, last;
   logic signed [DATA_WIDTH-1:0] head_a, head_b, head_sel;
   slm_pkg::rsp_type rsp_ff, rsp_in;

   // lengths above the store depth count as the depth
   assign na = (len_first > slm_pkg::LEN_W'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH)
                                                         : CNT_W'(len_first);
   assign nb = (len_second > slm_pkg::LEN_W'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH)
                                                          : CNT_W'(len_second);

   // loading
   assign wr_a = cmd.load && !req_data.from_second && (fill_a_ff < na);
   assign wr_b = cmd.load &&  req_data.from_second && (fill_b_ff < nb);
   assign fill_a_next = fill_a_ff + CNT_W'(wr_a);
   assign fill_b_next = fill_b_ff + CNT_W'(wr_b);
   assign done = (fill_a_next >= na) && (fill_b_next >= nb);

   always_comb begin
      fill_a_in = fill_a_ff;
      fill_b_in = fill_b_ff;
      if (cmd.load) begin
         fill_a_in = done ? '0 : fill_a_next;
         fill_b_in = done ? '0 : fill_b_next;
      end
   end

   // merge step
   assign a_left   = ia_ff < na;
   assign b_left   = ib_ff < nb;
   assign take_a   = a_left && (!b_left || (head_a < head_b));
   assign ia_step  = ia_ff + CNT_W'(take_a);
   assign ib_step  = ib_ff + CNT_W'(!take_a);
   assign last     = (ia_step == na) && (ib_step == nb);
   assign head_sel = take_a ? head_a : head_b;

   always_comb begin
      ia_in  = ia_ff;
      ib_in  = ib_ff;
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         ia_in = last ? '0 : ia_step;
         ib_in = last ? '0 : ib_step;
         rsp_in.merged_value     = slm_pkg::VALUE_W'(head_sel);
         rsp_in.came_from_second = !take_a;
         rsp_in.is_last          = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_a_ff <= '0;
         fill_b_ff <= '0;
         ia_ff     <= '0;
         ib_ff     <= '0;
      end else begin
         fill_a_ff <= fill_a_in;
         fill_b_ff <= fill_b_in;
         ia_ff     <= ia_in;
         ib_ff     <= ib_in;
      end
      rsp_ff <= rsp_in;
   end

   slm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LIST_DEPTH)) u_first_store (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (fill_a_ff[AW-1:0]),
      .wr_data (req_data.value[DATA_WIDTH-1:0]),
      .rd_addr (ia_in[AW-1:0]),
      .rd_data (head_a)
   );

   slm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LIST_DEPTH)) u_second_store (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (fill_b_ff[AW-1:0]),
      .wr_data (req_data.value[DATA_WIDTH-1:0]),
      .rd_addr (ib_in[AW-1:0]),
      .rd_data (head_b)
   );

   assign status.done  = done;
   assign status.empty = (na == '0) && (nb == '0);
   assign status.last  = last;
   assign rsp_data     = rsp_ff;

endmodule

// ===== src/slm_ctrl.sv =====
// controller state machine of the sorted list merger
module slm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  slm_pkg::status_type  status,
   output slm_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_MERGE
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff;

   assign cmd.load = start && (state_ff == ST_IDLE);
   assign cmd.emit = (state_ff == ST_MERGE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load && status.done && !status.empty) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.emit;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== src/sorted_list_merger_unit.sv =====
// top level of the sorted list merger
//
// two ascending lists of signed values are loaded one element per transaction
// (start high while busy is low), each element tagged with its list; elements
// beyond a list's length register (len_first, len_second, capped at the store
// depth) are dropped. on the transaction that fills both lists the block raises
// busy until the last result is issued: a prime state primes the registered read
// port of each list store, then the merge loop issues one result per cycle, the
// smaller head first and the second list's head on a tie, then the leftover
// tail. results show on rsp_data for exactly one cycle under rsp_strobe,
// starting after the prime state, registered together with the strobe, and the
// last one carries is_last. the receiver cannot stall this stream. when both
// lengths are zero no result is produced and busy stays low. after a run both
// fill counts are back at zero. no element is taken while a merge runs, since
// busy stays high until the last result is issued.
// the lengths may only be written while busy is low and no run is pending.
module sorted_list_merger_unit #(
   parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
   parameter int DATA_WIDTH = slm_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // item channel
   input  logic                              start,
   output logic                              busy,
   input  slm_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_strobe,
   output slm_pkg::rsp_type                  rsp_data,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [slm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [slm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [slm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   logic [slm_pkg::LEN_W-1:0] len_first_ff, len_first_in;
   logic [slm_pkg::LEN_W-1:0] len_second_ff, len_second_in;
   logic                      csr_write;
   logic                      csr_index;
   slm_pkg::cmd_type          cmd;
   slm_pkg::status_type       status;

   // register port: pready is always high, index from address bit 2
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      len_first_in  = len_first_ff;
      len_second_in = len_second_ff;
      if (csr_write) begin
         unique case (csr_index)
            slm_pkg::REG_LEN_FIRST:  len_first_in  = pwdata[slm_pkg::LEN_W-1:0];
            slm_pkg::REG_LEN_SECOND: len_second_in = pwdata[slm_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_first_ff  <= '0;
         len_second_ff <= '0;
      end else begin
         len_first_ff  <= len_first_in;
         len_second_ff <= len_second_in;
      end
   end

   // read back the addressed length
   assign prdata = (csr_index == slm_pkg::REG_LEN_SECOND)
                 ? slm_pkg::CSR_DATA_W'(len_second_ff)
                 : slm_pkg::CSR_DATA_W'(len_first_ff);

   // sequencing of load, prime and merge
   slm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // stores, counters, pointers and the result register
   slm_datapath #(.LIST_DEPTH(LIST_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .len_first  (len_first_ff),
      .len_second (len_second_ff),
      .status     (status),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // a result that is not the last one means the run is still going
   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.is_last) |-> busy)
      else $error("result before end of run while idle");

   // the last result of a run is never followed directly by another
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_last) |=> !rsp_strobe)
      else $error("result right after the last one");

   // a run opens with the prime cycle, so no result on its first busy cycle
   a_prime_first: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_strobe)
      else $error("result in prime cycle");
`endif

endmodule

// ===== test/sorted_list_merger_unit_tb.sv =====
// self-checking testbench of the sorted list merger unit
`timescale 1ns / 1ps

module sorted_list_merger_unit_tb;

   localparam int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF;
   localparam int VALUE_W    = slm_pkg::VALUE_W;
   localparam int LEN_W      = slm_pkg::LEN_W;
   localparam int CSR_ADDR_W = slm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = slm_pkg::CSR_DATA_W;
   // slowest legal run stays far below this, even with long gaps and full lists
   localparam int unsigned CYCLE_LIMIT = 400000;
   // loaded elements wanted from the random part
   localparam int unsigned RANDOM_LOADS = 260;

   typedef logic signed [VALUE_W-1:0] word_q_type[$];

   // mirror of the merger: list stores, fill counts, lengths, queue of merged output
   class merge_scoreboard;
      logic signed [VALUE_W-1:0] first_store[LIST_DEPTH];
      logic signed [VALUE_W-1:0] second_store[LIST_DEPTH];
      int unsigned               first_fill;
      int unsigned               second_fill;
      logic [LEN_W-1:0]          len_first_reg;
      logic [LEN_W-1:0]          len_second_reg;
      slm_pkg::rsp_type          expected_merge[$];
      int unsigned               mismatches;

      function new();
         first_fill     = 0;
         second_fill    = 0;
         len_first_reg  = '0;
         len_second_reg = '0;
         mismatches     = 0;
      endfunction

      // a length above the store depth counts as the depth
      function int unsigned cap_len(logic [LEN_W-1:0] len);
         return (len > LIST_DEPTH) ? LIST_DEPTH : int'(len);
      endfunction

      // elements still needed before the given list is full
      function int unsigned missing(bit second);
         int unsigned n;
         int unsigned f;
         n = cap_len(second ? len_second_reg : len_first_reg);
         f = second ? second_fill : first_fill;
         return (n > f) ? n - f : 0;
      endfunction

      function void set_length(logic sel, logic [LEN_W-1:0] len);
         if (sel == slm_pkg::REG_LEN_SECOND) second_len_write(len);
         else len_first_reg = len;
      endfunction

      function void second_len_write(logic [LEN_W-1:0] len);
         len_second_reg = len;
      endfunction

      function void add_expected(logic signed [VALUE_W-1:0] v, logic src, logic last);
         slm_pkg::rsp_type r;
         r.merged_value     = v;
         r.came_from_second = src;
         r.is_last          = last;
         expected_merge.push_back(r);
      endfunction

      // note one accepted element; returns 1 when it was stored in a list
      function bit load_element(slm_pkg::req_type item);
         int unsigned n_first;
         int unsigned n_second;
         int unsigned ia;
         int unsigned ib;
         int unsigned total;
         bit          stored;
         n_first  = cap_len(len_first_reg);
         n_second = cap_len(len_second_reg);
         stored   = 1'b0;
         if (item.from_second) begin
            if (second_fill < n_second) begin
               second_store[second_fill] = item.value;
               second_fill++;
               stored = 1'b1;
            end
         end else begin
            if (first_fill < n_first) begin
               first_store[first_fill] = item.value;
               first_fill++;
               stored = 1'b1;
            end
         end
         if (first_fill < n_first || second_fill < n_second) return stored;
         // both lists full: smaller head first, second list wins a tie, then the tail
         total = n_first + n_second;
         ia    = 0;
         ib    = 0;
         while (ia + ib < total) begin
            if (ib >= n_second || (ia < n_first && first_store[ia] < second_store[ib])) begin
               add_expected(first_store[ia], 1'b0, ia + ib + 1 == total);
               ia++;
            end else begin
               add_expected(second_store[ib], 1'b1, ia + ib + 1 == total);
               ib++;
            end
         end
         first_fill  = 0;
         second_fill = 0;
         return stored;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      task check_merged(slm_pkg::rsp_type got);
         slm_pkg::rsp_type want;
         if (expected_merge.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing expected", got.merged_value));
            return;
         end
         want = expected_merge.pop_front();
         if (got.merged_value !== want.merged_value)
            report_mismatch($sformatf("merged_value got %0d want %0d",
                                      got.merged_value, want.merged_value));
         if (got.came_from_second !== want.came_from_second)
            report_mismatch($sformatf("came_from_second got %b want %b (value %0d)",
                                      got.came_from_second, want.came_from_second,
                                      want.merged_value));
         if (got.is_last !== want.is_last)
            report_mismatch($sformatf("is_last got %b want %b (value %0d)",
                                      got.is_last, want.is_last, want.merged_value));
      endtask

      function int unsigned pending();
         return expected_merge.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   slm_pkg::req_type      req_data;
   logic                  rsp_strobe;
   slm_pkg::rsp_type      rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   merge_scoreboard sb = new();
   int unsigned     loaded_count;
   int unsigned     cycle_count;

   sorted_list_merger_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // every strobed result is one transaction, the receiver never stalls
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_merged(rsp_data);
   end

   // present one element and hold it until a clock edge sees busy low
   task automatic send_item(input logic src, input logic signed [VALUE_W-1:0] v);
      slm_pkg::req_type item;
      item.from_second = src;
      item.value       = v;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (sb.load_element(item)) loaded_count++;
   endtask

   // random gap before an element, mostly short, now and then long
   task automatic idle_gap(input bit steady);
      int unsigned r;
      int unsigned n;
      n = 0;
      if (!steady) begin
         r = $urandom_range(0, 99);
         if (r < 45) n = 0;
         else if (r < 85) n = $urandom_range(1, 3);
         else if (r < 97) n = $urandom_range(4, 12);
         else n = $urandom_range(20, 40);
      end
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // block idle: all merged values seen, then room for a run still in flight
   task automatic wait_quiet();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // apb write, psel left high so a following access can chain without a drop
   task automatic csr_write(input logic sel, input logic [LEN_W-1:0] len);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      // upper bits are junk, only the length field is kept
      pwdata  <= {(CSR_DATA_W - LEN_W)'($urandom), len};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_length(sel, len);
   endtask

   task automatic csr_read(input logic sel);
      logic [CSR_DATA_W-1:0] want;
      want    = CSR_DATA_W'((sel == slm_pkg::REG_LEN_SECOND) ? sb.len_second_reg
                                                             : sb.len_first_reg);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         sb.report_mismatch($sformatf("length register %b reads %0h want %0h",
                                      sel, prdata, want));
   endtask

   task automatic set_lengths(input logic [LEN_W-1:0] len_a, input logic [LEN_W-1:0] len_b);
      wait_quiet();
      csr_write(slm_pkg::REG_LEN_FIRST, len_a);
      csr_write(slm_pkg::REG_LEN_SECOND, len_b);
      csr_read(slm_pkg::REG_LEN_FIRST);
      csr_read(slm_pkg::REG_LEN_SECOND);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // style 0 wide ascending, 1 narrow ascending with many ties, 2 unsorted noise
   function automatic word_q_type make_list(int unsigned n, int unsigned style);
      word_q_type  q;
      longint      v;
      int unsigned i;
      case (style)
         1:       v = -longint'($urandom_range(0, 2));
         default: begin
            case ($urandom_range(0, 7))
               0:       v = 0;
               1:       v = -64'sd2147483648;
               default: v = -64'sd2147483648 + longint'($urandom_range(0, 32'h7fff_ffff));
            endcase
         end
      endcase
      for (i = 0; i < n; i++) begin
         if (style == 2) begin
            q.push_back($urandom);
         end else begin
            // saturate at the top so the maximum value shows up as well
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            q.push_back(v[VALUE_W-1:0]);
            if (style == 1) v = v + longint'($urandom_range(0, 1));
            else v = v + longint'($urandom_range(0, 32'hffff_ffff / (n + 1)));
         end
      end
      return q;
   endfunction

   // load both lists up to their lengths in random interleaving; partial stops short
   task automatic run_merge(input bit partial);
      word_q_type  first_vals;
      word_q_type  second_vals;
      int unsigned style;
      int unsigned stop_at;
      int unsigned sent;
      bit          steady;
      bit          side;
      style  = ($urandom_range(0, 9) < 6) ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      steady = ($urandom_range(0, 3) == 0);
      if (sb.cap_len(sb.len_first_reg) == 0 && sb.cap_len(sb.len_second_reg) == 0) begin
         // both lengths zero: every element is dropped and nothing comes out
         repeat (3) begin
            idle_gap(steady);
            send_item(1'($urandom_range(0, 1)), $urandom);
         end
         return;
      end
      first_vals  = make_list(sb.missing(1'b0), style);
      second_vals = make_list(sb.missing(1'b1), style);
      if (first_vals.size() + second_vals.size() == 0) begin
         // lists already hold their lengths: any element sets off the merge
         idle_gap(steady);
         send_item(1'($urandom_range(0, 1)), $urandom);
         return;
      end
      stop_at = first_vals.size() + second_vals.size();
      if (partial) stop_at = $urandom_range(0, stop_at - 1);
      sent = 0;
      while (sent < stop_at) begin
         idle_gap(steady);
         // element for a list that is already full gets dropped
         if (first_vals.size() == 0 && $urandom_range(0, 9) == 0) begin
            send_item(1'b0, $urandom);
         end else if (second_vals.size() == 0 && $urandom_range(0, 9) == 0) begin
            send_item(1'b1, $urandom);
         end else begin
            if (first_vals.size() == 0) side = 1'b1;
            else if (second_vals.size() == 0) side = 1'b0;
            else side = 1'($urandom_range(0, 1));
            if (side) send_item(1'b1, second_vals.pop_front());
            else send_item(1'b0, first_vals.pop_front());
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned      base_loads;
      int unsigned      runs;
      int unsigned      r;
      int unsigned      pick;
      logic [LEN_W-1:0] len_a;
      logic [LEN_W-1:0] len_b;

      start        <= 1'b0;
      req_data     <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      reset        <= 1'b1;
      loaded_count = 0;
      cycle_count  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // both lengths zero: elements go nowhere and no result comes out
      set_lengths(6'd0, 6'd0);
      send_item(1'b0, 32'sh8000_0000);
      send_item(1'b1, 32'sh7fff_ffff);

      // single element lists at the value extremes
      set_lengths(6'd1, 6'd1);
      send_item(1'b0, 32'sh8000_0000);
      send_item(1'b1, 32'sh7fff_ffff);
      // equal heads, second list goes first
      send_item(1'b1, 32'sd5);
      send_item(1'b0, 32'sd5);

      // ties at -1 and 0, plus an element for the full first list that gets dropped
      set_lengths(6'd3, 6'd2);
      send_item(1'b0, -32'sd1);
      send_item(1'b0, 32'sd0);
      send_item(1'b1, -32'sd1);
      send_item(1'b0, 32'sd1);
      send_item(1'b0, 32'sd99);
      send_item(1'b1, 32'sd0);

      // empty first list: merge is the second list copied out
      set_lengths(6'd0, 6'd2);
      send_item(1'b0, 32'sd7);
      send_item(1'b1, 32'sd3);
      send_item(1'b1, 32'sd4);

      // first list length lowered below its fill: only its head is merged
      set_lengths(6'd3, 6'd1);
      send_item(1'b0, 32'sd10);
      send_item(1'b0, 32'sd20);
      set_lengths(6'd1, 6'd1);
      send_item(1'b1, 32'sd15);

      // random phases: new lengths, then one or more merge runs
      base_loads = loaded_count;
      while (loaded_count - base_loads < RANDOM_LOADS) begin
         pick = $urandom_range(0, 99);
         r    = $urandom_range(1, 8);
         if (pick < 5) begin
            len_a = 6'd0;
            len_b = 6'd0;
         end else if (pick < 12) begin
            len_a = $urandom_range(0, 1) ? 6'd0 : LEN_W'(r);
            len_b = (len_a == 6'd0) ? LEN_W'(r) : 6'd0;
         end else if (pick < 18) begin
            // one list at full depth
            len_a = $urandom_range(0, 1) ? 6'd32 : LEN_W'($urandom_range(0, 4));
            len_b = (len_a == 6'd32) ? LEN_W'($urandom_range(0, 4)) : 6'd32;
         end else if (pick < 23) begin
            // length above the depth counts as the depth
            len_a = $urandom_range(0, 1) ? 6'd63 : LEN_W'($urandom_range(33, 62));
            len_b = LEN_W'($urandom_range(0, 4));
            if ($urandom_range(0, 1)) begin
               len_b = len_a;
               len_a = LEN_W'($urandom_range(0, 4));
            end
         end else begin
            len_a = LEN_W'(r);
            len_b = LEN_W'($urandom_range(1, 8));
         end
         set_lengths(len_a, len_b);
         runs = (sb.cap_len(len_a) > 8 || sb.cap_len(len_b) > 8) ? 1 : $urandom_range(1, 3);
         for (int unsigned i = 0; i < runs; i++)
            run_merge(i + 1 == runs && $urandom_range(0, 6) == 0);
      end

      // drain, then keep the clock running to catch stray results
      wait_quiet();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
